>>> rtl/core/mbpr_pkg.sv
// Shared constants, operation codes and cell control type for the pattern replacer.
package mbpr_pkg;

    localparam int PATTERN_MAX_DEF = 128;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int TIDX_W = 7;
    localparam int CFG_W  = 8;
    localparam int CIDX_W = 1;

    localparam logic [OP_W-1:0] OP_LOAD_PAT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_REP = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA     = 2'd2;
    localparam logic [OP_W-1:0] OP_DRAIN    = 2'd3;

    localparam logic [CIDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
    localparam logic [CIDX_W-1:0] REG_REPLACE_LENGTH = 1'd1;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic              load_pat;
        logic              load_rep;
        logic              apply;
        logic [BYTE_W-1:0] data;
        logic [TIDX_W-1:0] tbl_idx;
        logic              must;
    } t_cell_ctrl;

endpackage

>>> rtl/core/mbpr_in_if.sv
// Input channel: operation item with valid/ready handshake.
interface mbpr_in_if;
    import mbpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] byte_value;
    logic [TIDX_W-1:0] table_index;
    logic              must_match;

    modport source (output valid, operation, byte_value, table_index, must_match,
                    input ready);
    modport sink   (input valid, operation, byte_value, table_index, must_match,
                    output ready);
endinterface

>>> rtl/core/mbpr_out_if.sv
// Output channel: one byte leaving the window with its status bits.
interface mbpr_out_if;
    import mbpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              was_replaced;
    logic              last;
    logic              region_patched;

    modport source (output valid, out_byte, was_replaced, last, region_patched,
                    input ready);
    modport sink   (input valid, out_byte, was_replaced, last, region_patched,
                    output ready);
endinterface

>>> rtl/core/mbpr_cell.sv
// One window position: pattern, mask and replacement entry plus the window byte.
module mbpr_cell #(
    parameter int PATTERN_MAX = mbpr_pkg::PATTERN_MAX_DEF,
    parameter int CELL_IDX    = 0,
    parameter int FW          = $clog2(PATTERN_MAX + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mbpr_pkg::t_cell_ctrl     i_ctrl,
    input  logic [FW-1:0]            i_push_pos,
    input  logic [FW-1:0]            i_len,
    input  logic [FW-1:0]            i_rep_len,
    input  logic [mbpr_pkg::BYTE_W-1:0] i_next_byte,
    input  logic                     i_next_mark,
    output logic [mbpr_pkg::BYTE_W-1:0] o_byte,
    output logic                     o_mark,
    output logic                     o_hit
);
    import mbpr_pkg::*;

    localparam int IW = (FW > TIDX_W) ? FW : TIDX_W;

    logic [BYTE_W-1:0] r_pat;
    logic              r_care;
    logic [BYTE_W-1:0] r_rep;
    logic [BYTE_W-1:0] r_win;
    logic              r_mark;

    logic sel_tbl;
    logic sel_push;
    logic sel_apply;
    logic beyond_len;

    assign sel_tbl    = (IW'(i_ctrl.tbl_idx) == IW'(CELL_IDX));
    assign sel_push   = i_ctrl.push && (i_push_pos == FW'(CELL_IDX));
    assign sel_apply  = i_ctrl.apply && (FW'(CELL_IDX) < i_rep_len);
    assign beyond_len = (FW'(CELL_IDX) >= i_len);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_pat && sel_tbl) begin
            r_pat  <= i_ctrl.data;
            r_care <= i_ctrl.must;
        end
        if (i_ctrl.load_rep && sel_tbl) begin
            r_rep <= i_ctrl.data;
        end
        if (sel_apply) begin
            r_win <= r_rep;
        end else if (sel_push) begin
            r_win <= i_ctrl.data;
        end else if (i_ctrl.pop) begin
            r_win <= i_next_byte;
        end
    end

    // marks past the fill stay zero: zeros enter at the far end of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else if (sel_apply) begin
            r_mark <= 1'b1;
        end else if (sel_push) begin
            r_mark <= 1'b0;
        end else if (i_ctrl.pop) begin
            r_mark <= i_next_mark;
        end
    end

    assign o_byte = r_win;
    assign o_mark = r_mark;
    assign o_hit  = !r_care || (r_win == r_pat) || beyond_len;

endmodule

>>> rtl/core/masked_byte_pattern_replace.sv
// Top level: masked byte pattern search and replace over a chain of window cells.
//
// Bytes stream through a row of PATTERN_MAX cells, each holding one window byte with its
// pattern byte, care bit and replacement byte. A data item shifts the window by one cell
// once it holds at least pattern_length bytes, and appends its byte; when that leaves the
// window holding exactly pattern_length bytes, the next cycle compares the first
// pattern_length cells, wildcards aside, against their pattern bytes and patches the first
// replace_length cells on a match. A result sits in an output register; the next item is
// taken once no compare is pending and that register is empty or its byte is being taken
// in the same cycle. Pattern and replacement tables must be loaded before use;
// pattern_length and replace_length are clamped to 1..PATTERN_MAX and to pattern_length.
module masked_byte_pattern_replace #(
    parameter int PATTERN_MAX = mbpr_pkg::PATTERN_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mbpr_in_if.sink                     i_in,
    mbpr_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [mbpr_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [mbpr_pkg::CFG_W-1:0]  i_cfg_data
);
    import mbpr_pkg::*;

    localparam int FW = $clog2(PATTERN_MAX + 1);
    localparam int CW = (FW > CFG_W) ? FW : CFG_W;

    logic [CFG_W-1:0] r_pat_len;
    logic [CFG_W-1:0] r_rep_len;
    logic [FW-1:0]    r_fill;
    logic             r_any;
    logic             r_match_pend;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_mark;
    logic              r_out_last;
    logic              r_out_patched;

    logic [CW-1:0] len_w;
    logic [CW-1:0] len_c;
    logic [CW-1:0] rep_w;
    logic [FW-1:0] len;
    logic [FW-1:0] rep_len;

    logic          in_fire;
    logic          is_data;
    logic          is_drain;
    logic          pop;
    logic          push;
    logic          apply;
    logic          drain_last;
    logic [FW-1:0] fill_pop;
    logic [FW-1:0] n_fill;

    t_cell_ctrl    ctrl;

    logic [BYTE_W-1:0]      w_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_mark;
    logic [PATTERN_MAX-1:0] w_hit;

    // clamp register values to the legal ranges
    always_comb begin
        len_w = CW'(r_pat_len);
        if (len_w == '0) begin
            len_c = CW'(1);
        end else if (len_w > CW'(PATTERN_MAX)) begin
            len_c = CW'(PATTERN_MAX);
        end else begin
            len_c = len_w;
        end
        rep_w = CW'(r_rep_len);
        if (rep_w > len_c) begin
            rep_w = len_c;
        end
    end

    assign len     = FW'(len_c);
    assign rep_len = FW'(rep_w);

    assign i_in.ready = !r_match_pend && (!r_out_valid || o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;
    assign is_data    = (i_in.operation == OP_DATA);
    assign is_drain   = (i_in.operation == OP_DRAIN);

    assign pop        = in_fire && ((is_data && (r_fill >= len)) ||
                                    (is_drain && (r_fill != '0)));
    assign fill_pop   = r_fill - FW'(pop);
    assign push       = in_fire && is_data && (fill_pop < FW'(PATTERN_MAX));
    assign n_fill     = fill_pop + FW'(push);
    assign drain_last = is_drain && (r_fill == FW'(1));
    assign apply      = r_match_pend && (&w_hit);

    always_comb begin
        ctrl.pop      = pop;
        ctrl.push     = push;
        ctrl.load_pat = in_fire && (i_in.operation == OP_LOAD_PAT);
        ctrl.load_rep = in_fire && (i_in.operation == OP_LOAD_REP);
        ctrl.apply    = apply;
        ctrl.data     = i_in.byte_value;
        ctrl.tbl_idx  = i_in.table_index;
        ctrl.must     = i_in.must_match;
    end

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        logic [BYTE_W-1:0] nb;
        logic              nm;
        if (g == PATTERN_MAX - 1) begin : g_end
            assign nb = '0;
            assign nm = 1'b0;
        end else begin : g_mid
            assign nb = w_byte[g+1];
            assign nm = w_mark[g+1];
        end
        mbpr_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .CELL_IDX    (g),
            .FW          (FW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_push_pos  (fill_pop),
            .i_len       (len),
            .i_rep_len   (rep_len),
            .i_next_byte (nb),
            .i_next_mark (nm),
            .o_byte      (w_byte[g]),
            .o_mark      (w_mark[g]),
            .o_hit       (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len    <= CFG_W'(1);
            r_rep_len    <= '0;
            r_fill       <= '0;
            r_any        <= 1'b0;
            r_match_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN_LENGTH: r_pat_len <= i_cfg_data;
                    REG_REPLACE_LENGTH: r_rep_len <= i_cfg_data;
                    default: ;
                endcase
            end
            r_fill       <= n_fill;
            r_match_pend <= in_fire && is_data && (n_fill == len);
            if (apply) begin
                r_any <= 1'b1;
            end else if (in_fire && is_drain && (r_fill <= FW'(1))) begin
                // empty drain or end of region starts a new region
                r_any <= 1'b0;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_byte    <= w_byte[0];
            r_out_mark    <= w_mark[0];
            r_out_last    <= drain_last;
            r_out_patched <= drain_last && r_any;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.was_replaced   = r_out_mark;
    assign o_out.last           = r_out_last;
    assign o_out.region_patched = r_out_patched;

endmodule

>>> verif/mbpr_replace_checker.sv
// Watches the pattern replacer channels, predicts each output byte and compares it.
module mbpr_replace_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mbpr_in_if                          i_in_mon,
    mbpr_out_if                         i_out_mon,
    input  logic                        i_cfg_we,
    input  logic [mbpr_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [mbpr_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          o_errors,
    output int                          o_pending
);
    import mbpr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              was_replaced;
        logic              last;
        logic              region_patched;
    } t_out_byte;

    logic [BYTE_W-1:0] pat_tbl  [PATTERN_MAX_DEF];
    logic              care_tbl [PATTERN_MAX_DEF];
    logic [BYTE_W-1:0] rep_tbl  [PATTERN_MAX_DEF];
    logic [BYTE_W-1:0] win_byte [PATTERN_MAX_DEF];
    logic              win_mark [PATTERN_MAX_DEF];
    int                win_fill;
    logic              match_seen;
    logic [CFG_W-1:0]  pat_len_reg;
    logic [CFG_W-1:0]  rep_len_reg;
    t_out_byte         expected_bytes[$];
    int                err_count = 0;

    function automatic int window_length();
        int len = int'(pat_len_reg);
        if (len < 1) len = 1;
        if (len > PATTERN_MAX_DEF) len = PATTERN_MAX_DEF;
        return len;
    endfunction

    function automatic void expect_byte(input t_out_byte e);
        expected_bytes.insert(expected_bytes.size(), e);
    endfunction

    function automatic void shift_out(output logic [BYTE_W-1:0] b, output logic m);
        b = win_byte[0];
        m = win_mark[0];
        for (int i = 0; i < win_fill - 1; i++) begin
            win_byte[i] = win_byte[i+1];
            win_mark[i] = win_mark[i+1];
        end
        win_fill--;
        win_mark[win_fill] = 1'b0;
    endfunction

    // wildcard cells are skipped; the patch lands on the oldest bytes of the window
    function automatic void match_and_patch(input int len);
        int rl = int'(rep_len_reg);
        for (int i = 0; i < len; i++) begin
            if (care_tbl[i] && win_byte[i] != pat_tbl[i]) return;
        end
        if (rl > len) rl = len;
        for (int i = 0; i < rl; i++) begin
            win_byte[i] = rep_tbl[i];
            win_mark[i] = 1'b1;
        end
        match_seen = 1'b1;
    endfunction

    function automatic void predict_item(input logic [OP_W-1:0] op,
                                         input logic [BYTE_W-1:0] val,
                                         input logic [TIDX_W-1:0] idx,
                                         input logic must);
        int                len = window_length();
        logic [BYTE_W-1:0] b;
        logic              m;
        case (op)
            OP_LOAD_PAT: begin
                pat_tbl[idx]  = val;
                care_tbl[idx] = must;
            end
            OP_LOAD_REP: rep_tbl[idx] = val;
            OP_DATA: begin
                if (win_fill >= len) begin
                    shift_out(b, m);
                    expect_byte(t_out_byte'{b, m, 1'b0, 1'b0});
                end
                // a full window drops the new byte
                if (win_fill < PATTERN_MAX_DEF) begin
                    win_byte[win_fill] = val;
                    win_mark[win_fill] = 1'b0;
                    win_fill++;
                end
                if (win_fill == len) match_and_patch(len);
            end
            default: begin
                if (win_fill == 0) begin
                    match_seen = 1'b0;
                end else begin
                    shift_out(b, m);
                    if (win_fill == 0) begin
                        expect_byte(t_out_byte'{b, m, 1'b1, match_seen});
                        match_seen = 1'b0;
                    end else begin
                        expect_byte(t_out_byte'{b, m, 1'b0, 1'b0});
                    end
                end
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_byte got;
        t_out_byte want;
        if (!i_rst_n) begin
            win_fill    = 0;
            match_seen  = 1'b0;
            pat_len_reg = 8'd1;
            rep_len_reg = 8'd0;
            foreach (win_mark[i]) win_mark[i] = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.out_byte, i_out_mon.was_replaced,
                        i_out_mon.last, i_out_mon.region_patched};
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected none, got %0h", got.out_byte);
                    err_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    compare_field("out_byte", int'(want.out_byte), int'(got.out_byte));
                    compare_field("was_replaced", int'(want.was_replaced),
                                  int'(got.was_replaced));
                    compare_field("last", int'(want.last), int'(got.last));
                    compare_field("region_patched", int'(want.region_patched),
                                  int'(got.region_patched));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN_LENGTH: pat_len_reg = i_cfg_data;
                    REG_REPLACE_LENGTH: rep_len_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_item(i_in_mon.operation, i_in_mon.byte_value,
                             i_in_mon.table_index, i_in_mon.must_match);
        end
        o_errors  <= err_count;
        o_pending <= expected_bytes.size();
    end

endmodule

>>> verif/tb_masked_byte_pattern_replace.sv
// Stimulus and verdict for the masked byte pattern replacer.
module tb_masked_byte_pattern_replace;
    import mbpr_pkg::*;

    localparam int RANDOM_ITEMS    = 1570;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 200;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                fail_count;
    int                pending_bytes;

    // what the stimulus has loaded, so it can build matching byte runs
    logic [BYTE_W-1:0] pat_shadow  [PATTERN_MAX_DEF];
    logic              care_shadow [PATTERN_MAX_DEF];
    int                pat_len_eff = 1;
    int                win_fill    = 0;
    int                items_sent  = 0;
    bit                send_burst  = 1'b0;

    mbpr_in_if  in_ch ();
    mbpr_out_if out_ch ();

    masked_byte_pattern_replace uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mbpr_replace_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending_bytes)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] val,
                             input logic [TIDX_W-1:0] idx, input logic must);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.byte_value  <= val;
        in_ch.table_index <= idx;
        in_ch.must_match  <= must;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        case (op)
            OP_LOAD_PAT: begin
                pat_shadow[idx]  = val;
                care_shadow[idx] = must;
            end
            OP_DATA:  if (win_fill < pat_len_eff) win_fill++;
            OP_DRAIN: if (win_fill > 0) win_fill--;
            default: ;
        endcase
    endtask

    task automatic load_pattern(input int idx, input logic [BYTE_W-1:0] val, input logic must);
        send_item(OP_LOAD_PAT, val, TIDX_W'(idx), must);
    endtask

    task automatic load_replacement(input int idx, input logic [BYTE_W-1:0] val);
        send_item(OP_LOAD_REP, val, TIDX_W'(idx), 1'($urandom_range(0, 1)));
    endtask

    task automatic push_data(input logic [BYTE_W-1:0] val);
        send_item(OP_DATA, val, TIDX_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_one();
        send_item(OP_DRAIN, BYTE_W'($urandom), TIDX_W'($urandom_range(0, 127)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        // load items and the compare cycle leave no result to wait on
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_lengths(input logic [CFG_W-1:0] pl, input logic [CFG_W-1:0] rl);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= pl;
        @(posedge i_clk);
        cfg_index <= REG_REPLACE_LENGTH;
        cfg_data  <= rl;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        pat_len_eff = (pl == 0) ? 1 :
                      ((int'(pl) > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pl));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: load_pattern($urandom_range(0, 127), BYTE_W'($urandom),
                            1'($urandom_range(0, 1)));
            1: load_replacement($urandom_range(0, 127), BYTE_W'($urandom));
            default: drain_one();
        endcase
    endtask

    // one pass of the pattern; exact cells are corrupted now and then on short patterns
    task automatic send_pattern_copy();
        for (int i = 0; i < pat_len_eff; i++) begin
            if (care_shadow[i] && (pat_len_eff > 16 || $urandom_range(0, 11) != 0))
                push_data(pat_shadow[i]);
            else
                push_data(BYTE_W'($urandom));
        end
    endtask

    task automatic run_region();
        int copies;
        copies = (pat_len_eff > 16) ? 1 : $urandom_range(1, 3);
        for (int c = 0; c < copies; c++) begin
            repeat ($urandom_range(0, 3)) push_data(BYTE_W'($urandom));
            send_pattern_copy();
            if ($urandom_range(0, 7) == 0) send_noise();
        end
        // sometimes bytes stay held into the next region or length setting
        if ($urandom_range(0, 5) != 0)
            repeat (win_fill + $urandom_range(0, 2)) drain_one();
    endtask

    task automatic run_phase(input int phase_no);
        int               pick;
        int               regions;
        logic [CFG_W-1:0] pl;
        logic [CFG_W-1:0] rl;
        if (phase_no == 0) begin
            pl = 8'd128;
            rl = 8'd128;
        end else if (phase_no == 1) begin
            pl = 8'd255;
            rl = 8'd255;
        end else begin
            pick = $urandom_range(0, 39);
            if (pick == 0)      pl = 8'd128;
            else if (pick == 1) pl = 8'd255;
            else if (pick == 2) pl = 8'd0;
            else if (pick < 8)  pl = CFG_W'($urandom_range(9, 40));
            else                pl = CFG_W'($urandom_range(1, 8));
            pick = $urandom_range(0, 7);
            if (pick == 0)      rl = 8'd0;
            else if (pick == 1) rl = 8'd255;
            else if (pick == 2) rl = pl;
            else                rl = CFG_W'($urandom_range(0, 9));
        end
        send_burst = ($urandom_range(0, 3) == 0);
        set_lengths(pl, rl);
        repeat ($urandom_range(0, 3))
            load_pattern($urandom_range(0, pat_len_eff - 1), BYTE_W'($urandom),
                         1'($urandom_range(0, 1)));
        regions = (pat_len_eff > 16) ? 1 : $urandom_range(1, 3);
        repeat (regions) run_region();
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        bit burst;
        stall = 0;
        taken = 0;
        burst = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                taken++;
                if ($urandom_range(0, 31) == 0) burst = !burst;
                // long hold-off lets the block back up into its input
                if (taken == 300 || taken == 900) stall = HOLD_OFF_CYCLES;
                else stall = burst ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_masked_byte_pattern_replace: errors");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        int random_start;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_PATTERN_LENGTH;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_DATA;
        in_ch.byte_value  <= '0;
        in_ch.table_index <= '0;
        in_ch.must_match  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every table entry gets written before any compare can read it
        for (int i = 0; i < PATTERN_MAX_DEF; i++) begin
            load_pattern(i, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
            load_replacement(i, BYTE_W'($urandom));
        end

        // single exact byte; replace length clamps down to one
        load_pattern(0, 8'hFF, 1'b1);
        load_replacement(0, 8'h00);
        set_lengths(8'd0, 8'hFF);
        push_data(8'hFF);
        push_data(8'h00);
        drain_one();
        drain_one();

        // all wildcards match anything, zero replace length patches nothing
        load_pattern(0, 8'h00, 1'b0);
        load_pattern(1, 8'h5A, 1'b0);
        load_pattern(2, 8'hA5, 1'b0);
        set_lengths(8'd3, 8'd0);
        push_data(8'h00);
        push_data(8'hFF);
        push_data(8'h5A);
        repeat (3) drain_one();

        // region shorter than the pattern
        set_lengths(8'd4, 8'd4);
        push_data(8'h12);
        push_data(8'h34);
        repeat (2) drain_one();

        load_pattern(127, 8'h80, 1'b1);
        load_replacement(127, 8'h7F);

        phase_no = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            run_phase(phase_no);
            phase_no++;
        end
        repeat (win_fill + 1) drain_one();
        wait_idle();

        if (fail_count == 0)
            $display("tb_masked_byte_pattern_replace: clean");
        else
            $display("tb_masked_byte_pattern_replace: errors");
        $finish;
    end

endmodule
